// ----- hdl/tpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Throughput meter package
// Shared widths, reset values, register indexes, the configuration bundle
// and the controller state type of the batched throughput meter.
// ----------------------------------------------------------------------------
package tpm_pkg;

   // Fixed field widths of the result transaction.
   localparam int RATE_W     = 48;
   localparam int TOTAL_W    = 48;
   localparam int RSP_DATA_W = 2 * RATE_W + 2 * TOTAL_W;

   // Interval packet counter and configuration register widths.
   localparam int WPKT_W     = 16;
   localparam int BATCH_W    = 16;
   localparam int MAXINT_W   = 32;

   // Register port geometry: two 32-bit registers at byte addresses 0 and 4.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register values after reset.
   localparam logic [BATCH_W-1:0]  BATCH_SIZE_RESET   = 16'd10;
   localparam logic [MAXINT_W-1:0] MAX_INTERVAL_RESET = 32'd100000;

   // Register index, taken from the word address bit.
   typedef enum logic [0:0] {
      CSR_IDX_BATCH_SIZE   = 1'b0,
      CSR_IDX_MAX_INTERVAL = 1'b1
   } tpm_csr_idx_type;

   // Configuration handed from the register block to the datapath.
   typedef struct packed {
      logic [BATCH_W-1:0]  batch_size;
      logic [MAXINT_W-1:0] max_interval;
   } tpm_cfg_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_PKT,
      ST_DIV_BIT,
      ST_FINISH
   } tpm_state_type;

endpackage

// ----- hdl/tpm_csr.sv -----
// ----------------------------------------------------------------------------
// Throughput meter registers
// Holds the batch size and maximum interval registers behind a simple
// peripheral bus port with a setup and an access cycle.
// ----------------------------------------------------------------------------
module tpm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [tpm_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [tpm_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [tpm_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready,
   output tpm_pkg::tpm_cfg_type                 cfg
);

   tpm_pkg::tpm_cfg_type     cfg_ff;
   tpm_pkg::tpm_csr_idx_type reg_idx;
   logic                     wr_en;

   // The word address bit selects the register; byte lane bits are ignored.
   assign reg_idx    = tpm_pkg::tpm_csr_idx_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // Register writes complete in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.batch_size   <= tpm_pkg::BATCH_SIZE_RESET;
         cfg_ff.max_interval <= tpm_pkg::MAX_INTERVAL_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            tpm_pkg::CSR_IDX_BATCH_SIZE: begin
               cfg_ff.batch_size <= csr_pwdata[tpm_pkg::BATCH_W-1:0];
            end
            tpm_pkg::CSR_IDX_MAX_INTERVAL: begin
               cfg_ff.max_interval <= csr_pwdata[tpm_pkg::MAXINT_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Read data is returned straight from the registers.
   always_comb begin
      case (reg_idx)
         tpm_pkg::CSR_IDX_BATCH_SIZE: begin
            csr_prdata = tpm_pkg::CSR_DATA_W'(cfg_ff.batch_size);
         end
         tpm_pkg::CSR_IDX_MAX_INTERVAL: begin
            csr_prdata = tpm_pkg::CSR_DATA_W'(cfg_ff.max_interval);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/tpm_divider.sv -----
// ----------------------------------------------------------------------------
// Throughput meter serial divider
// Restoring unsigned divider that shifts one dividend bit in and one
// quotient bit out per cycle until all dividend bits have been consumed.
// ----------------------------------------------------------------------------
module tpm_divider #(
   parameter int DIVIDEND_W = 52,
   parameter int DIVISOR_W  = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  rem_in;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVIDEND_W-1:0] quo_in;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // One restoring step: bring down the next dividend bit and try a subtract.
   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
   end

   // Sequencing: the dividend register fills with quotient bits from the bottom.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/batched_throughput_meter.sv -----
// ----------------------------------------------------------------------------
// Batched throughput meter
// A packet that keeps the interval open is added to it in the evaluate
// state; one that closes it runs the packet rate and then the bit rate
// division before its result is loaded into the output register.
// A new packet is taken only after the last result has been loaded; the
// two rate divisions share one serial divider that retires one
// quotient bit per cycle.
// Reset clears totals, interval state and rates to zero and loads defaults.
// ----------------------------------------------------------------------------
module batched_throughput_meter #(
   parameter int TIME_BITS   = 48,
   parameter int LENGTH_BITS = 20,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // Configuration port
   input  logic                                         csr_psel,
   input  logic                                         csr_penable,
   input  logic                                         csr_pwrite,
   input  logic [tpm_pkg::CSR_ADDR_W-1:0]               csr_paddr,
   input  logic [tpm_pkg::CSR_DATA_W-1:0]               csr_pwdata,
   output logic [tpm_pkg::CSR_DATA_W-1:0]               csr_prdata,
   output logic                                         csr_pready,
   // Packet event channel
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // tdata: packet_bits, arrival_time, zero padding to whole bytes
   input  logic [((LENGTH_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Result channel
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // tdata: bit_rate, packet_rate, packet_total, bit_total
   output logic [tpm_pkg::RSP_DATA_W-1:0]               rsp_tdata,
   // tuser: interval_closed
   output logic [0:0]                                   rsp_tuser
);

   localparam int WBITS_W = LENGTH_BITS + tpm_pkg::WPKT_W;
   localparam int DIV_W   = WBITS_W + FRAC_BITS;
   localparam int CMP_W   = (TIME_BITS > tpm_pkg::MAXINT_W) ? TIME_BITS : tpm_pkg::MAXINT_W;
   localparam int RATE_W  = tpm_pkg::RATE_W;
   localparam int TOTAL_W = tpm_pkg::TOTAL_W;
   localparam int WPKT_W  = tpm_pkg::WPKT_W;

   tpm_pkg::tpm_cfg_type   cfg;
   tpm_pkg::tpm_state_type state_ff;
   tpm_pkg::tpm_state_type state_in;

   logic [LENGTH_BITS-1:0] req_len;
   logic [TIME_BITS-1:0]   req_time;
   logic                   in_accept;

   logic [LENGTH_BITS-1:0] len_ff;
   logic [TIME_BITS-1:0]   now_ff;
   logic [TIME_BITS-1:0]   elapsed_ff;
   logic                   elapsed_zero_ff;
   logic [TOTAL_W-1:0]     packets_seen_ff;
   logic [TOTAL_W-1:0]     bits_seen_ff;
   logic [TIME_BITS-1:0]   window_start_ff;
   logic [WPKT_W-1:0]      window_packets_ff;
   logic [WBITS_W-1:0]     window_bits_ff;
   logic [RATE_W-1:0]      bit_rate_ff;
   logic [RATE_W-1:0]      packet_rate_ff;
   logic                   closed_ff;

   logic                         rsp_tvalid_ff;
   logic [tpm_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic                         rsp_tuser_ff;

   logic                   closing;
   logic                   out_free;
   logic                   div_start;
   logic                   div_sel_bits;
   logic [DIV_W-1:0]       div_dividend;
   logic                   div_done;
   logic [DIV_W-1:0]       div_quotient;
   logic                   rate_sat;
   logic [RATE_W-1:0]      rate_value;
   logic                   win_add;
   logic                   store_pkt;
   logic                   store_bit;
   logic                   load_out;

   // Register block
   tpm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Input field unpacking and handshake.
   assign req_len   = req_tdata[LENGTH_BITS-1:0];
   assign req_time  = req_tdata[LENGTH_BITS +: TIME_BITS];
   assign in_accept = req_tvalid & req_tready;

   // The interval closes on a full batch or once the time since its start reaches the maximum interval.
   assign closing  = (window_packets_ff >= cfg.batch_size) ||
                     (CMP_W'(elapsed_ff) >= CMP_W'(cfg.max_interval));
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tpm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = tpm_pkg::ST_EVAL;
            end
         end
         tpm_pkg::ST_EVAL: begin
            state_in = closing ? tpm_pkg::ST_DIV_PKT : tpm_pkg::ST_FINISH;
         end
         tpm_pkg::ST_DIV_PKT: begin
            if (div_done) begin
               state_in = tpm_pkg::ST_DIV_BIT;
            end
         end
         tpm_pkg::ST_DIV_BIT: begin
            if (div_done) begin
               state_in = tpm_pkg::ST_FINISH;
            end
         end
         tpm_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = tpm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpm_pkg::ST_IDLE;
         end
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_tready   = 1'b0;
      div_start    = 1'b0;
      div_sel_bits = 1'b0;
      win_add      = 1'b0;
      store_pkt    = 1'b0;
      store_bit    = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         tpm_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         tpm_pkg::ST_EVAL: begin
            div_start = closing;
            win_add   = !closing;
         end
         tpm_pkg::ST_DIV_PKT: begin
            store_pkt    = div_done;
            div_start    = div_done;
            div_sel_bits = 1'b1;
         end
         tpm_pkg::ST_DIV_BIT: begin
            store_bit = div_done;
         end
         tpm_pkg::ST_FINISH: begin
            load_out = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Rate divisions: packet count first, then bit count, both over the duration.
   assign div_dividend = div_sel_bits ? (DIV_W'(window_bits_ff) << FRAC_BITS)
                                      : (DIV_W'(window_packets_ff) << FRAC_BITS);

   tpm_divider #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (TIME_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // A zero duration or a quotient beyond the rate width saturates.
   assign rate_sat   = elapsed_zero_ff ||
                       ((DIV_W > RATE_W) && ((div_quotient >> RATE_W) != '0));
   assign rate_value = rate_sat ? '1 : RATE_W'(div_quotient);

   // Packet capture and running totals, updated when the transaction is taken.
   always_ff @(posedge clock) begin
      if (in_accept) begin
         len_ff          <= req_len;
         now_ff          <= req_time;
         elapsed_ff      <= req_time - window_start_ff;
         elapsed_zero_ff <= (req_time == window_start_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packets_seen_ff <= '0;
         bits_seen_ff    <= '0;
      end else if (in_accept) begin
         packets_seen_ff <= packets_seen_ff + 1'b1;
         bits_seen_ff    <= bits_seen_ff + TOTAL_W'(req_len);
      end
   end

   // Interval state and the last computed rates.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff   <= '0;
         window_packets_ff <= '0;
         window_bits_ff    <= '0;
         bit_rate_ff       <= '0;
         packet_rate_ff    <= '0;
         closed_ff         <= 1'b0;
      end else begin
         if (win_add) begin
            window_packets_ff <= window_packets_ff + 1'b1;
            window_bits_ff    <= window_bits_ff + WBITS_W'(len_ff);
            closed_ff         <= 1'b0;
         end
         if (store_pkt) begin
            packet_rate_ff <= rate_value;
         end
         // The new interval opens with this packet as its first member.
         if (store_bit) begin
            bit_rate_ff       <= rate_value;
            window_start_ff   <= now_ff;
            window_packets_ff <= WPKT_W'(1);
            window_bits_ff    <= WBITS_W'(len_ff);
            closed_ff         <= 1'b1;
         end
      end
   end

   // Output register decouples the result from the next packet's work.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata_ff <= {bits_seen_ff, packets_seen_ff, packet_rate_ff, bit_rate_ff};
         rsp_tuser_ff <= closed_ff;
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

endmodule

// ----- hdl/tpm_checker.sv -----
// ----------------------------------------------------------------------------
// Throughput meter port checker
// Watches the stream ports of the meter and checks ordering, occupancy and
// the consistency of totals and rates across result transactions.
// ----------------------------------------------------------------------------
module tpm_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tpm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [0:0]                         rsp_tuser
);

   localparam int RATES_W = 2 * tpm_pkg::RATE_W;
   localparam int TOTAL_W = tpm_pkg::TOTAL_W;

   logic [2:0]         outstanding_ff;
   logic [RATES_W-1:0] last_rates_ff;
   logic [TOTAL_W-1:0] last_total_ff;
   logic               in_take;
   logic               out_take;
   logic [TOTAL_W-1:0] pkt_total;

   assign in_take   = req_tvalid & req_tready;
   assign out_take  = rsp_tvalid & rsp_tready;
   assign pkt_total = rsp_tdata[RATES_W +: TOTAL_W];

   // Track transactions in flight and the last delivered rates and total.
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
         last_rates_ff  <= '0;
         last_total_ff  <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + {2'b00, in_take} - {2'b00, out_take};
         if (out_take) begin
            last_rates_ff <= rsp_tdata[RATES_W-1:0];
            last_total_ff <= pkt_total;
         end
      end
   end

   // A stalled result transaction holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // At most one packet in work and one result waiting.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= 3'd2)
      else $error("too many packets in flight");

   // Each result counts exactly one more packet than the one before.
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pkt_total == last_total_ff + 1'b1)
      else $error("packet total out of sequence");

   // Rates change only on a result that closed an interval.
   a_rates_keep: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[RATES_W-1:0] == last_rates_ff)
      else $error("rates changed without a closed interval");

endmodule

bind batched_throughput_meter tpm_checker u_tpm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
